@@ rtl/core/afvr_pkg.sv @@
// ============================================================================
// afvr_pkg - shared types and constants
// Command and status types between controller and datapath, register indexes
// and iteration counts of the shared arithmetic units.
// ============================================================================
package afvr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_X  = 3'd0;
  localparam logic [2:0] REG_TARGET_Y  = 3'd1;
  localparam logic [2:0] REG_TARGET_Z  = 3'd2;
  localparam logic [2:0] REG_GAIN      = 3'd3;
  localparam logic [2:0] REG_LIMIT     = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_STEP_TIME = 3'd6;

  // input item kinds
  localparam logic OP_POSE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // iteration counts of the serial units
  localparam int MUL_STEPS  = 41;  // multiplier bits (velocity magnitude)
  localparam int SQRT_STEPS = 42;  // root bits of an 84-bit radicand
  localparam int DIV_STEPS  = 72;  // dividend bits
  localparam int CNT_W      = 7;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_POSE,
    DP_LOAD,
    DP_GAIN,
    DP_MUL_START,
    DP_MUL_STEP,
    DP_SAVE_E,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_SAVE,
    DP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    MUL_EM_SQ,
    MUL_VM_SQ,
    MUL_VM_LIM
  } mul_src_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
    mul_src_e   src;
    logic       acc_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic clip;
    logic reached;
  } dp_status_t;

endpackage

@@ rtl/core/afvr_dp.sv @@
// ============================================================================
// afvr_dp - arithmetic datapath
// Holds configuration, pose and working registers; runs a shift-add
// multiplier, a digit-by-digit square root and a restoring divider.
// ============================================================================
module afvr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  afvr_pkg::dp_cmd_t    cmd_i,
  input  logic [31:0]          pos_x_i,
  input  logic [31:0]          pos_y_i,
  input  logic [31:0]          pos_z_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output afvr_pkg::dp_status_t status_o,
  output logic [31:0]          ref_x_o,
  output logic [31:0]          ref_y_o,
  output logic [31:0]          ref_z_o,
  output logic [31:0]          vel_x_o,
  output logic [31:0]          vel_y_o,
  output logic [31:0]          vel_z_o,
  output logic                 at_target_o
);

  logic [31:0] target_q [3];
  logic [15:0] gain_q;
  logic [30:0] limit_q;
  logic [30:0] thr_q;
  logic [23:0] step_q;

  logic [31:0] pos_q [3];
  logic [32:0] em_q [3];
  logic        neg_q [3];
  logic [40:0] vm_q [3];
  logic [61:0] thr_sq_q, lim_sq_q;
  logic [83:0] acc_q, mcand_q;
  logic [40:0] mplier_q;
  logic        reached_q;
  logic [83:0] rad_q;
  logic [43:0] srem_q;
  logic [41:0] root_q;
  logic [71:0] num_q;
  logic [41:0] drem_q;
  logic [30:0] quo_q;
  logic [31:0] ref_q [3];
  logic [31:0] vel_q [3];

  logic [33:0] e_w [3];
  logic [48:0] gprod;
  logic [83:0] mul_a;
  logic [40:0] mul_b;
  logic [45:0] s_rem2;
  logic [45:0] s_trial;
  logic [42:0] d_rem2;
  logic [30:0] vmag;
  logic [54:0] sprod;
  logic signed [33:0] step_s, rsum;
  logic [31:0] ref_w, vel_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q[0] <= 32'd8388608;
      target_q[1] <= 32'd3355443;
      target_q[2] <= 32'd8388608;
      gain_q      <= 16'd1280;
      limit_q     <= 31'd16777216;
      thr_q       <= 31'd1678;
      step_q      <= 24'd33554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afvr_pkg::REG_TARGET_X:  target_q[0] <= cfg_wdata_i;
        afvr_pkg::REG_TARGET_Y:  target_q[1] <= cfg_wdata_i;
        afvr_pkg::REG_TARGET_Z:  target_q[2] <= cfg_wdata_i;
        afvr_pkg::REG_GAIN:      gain_q      <= cfg_wdata_i[15:0];
        afvr_pkg::REG_LIMIT:     limit_q     <= cfg_wdata_i[30:0];
        afvr_pkg::REG_THRESHOLD: thr_q       <= cfg_wdata_i[30:0];
        afvr_pkg::REG_STEP_TIME: step_q      <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_w[i] = {{2{target_q[i][31]}}, target_q[i]} - {{2{pos_q[i][31]}}, pos_q[i]};
    end
    gprod = 49'(gain_q) * 49'(em_q[cmd_i.idx]);

    case (cmd_i.src)
      afvr_pkg::MUL_EM_SQ: begin
        mul_a = 84'(em_q[cmd_i.idx]);
        mul_b = 41'(em_q[cmd_i.idx]);
      end
      afvr_pkg::MUL_VM_SQ: begin
        mul_a = 84'(vm_q[cmd_i.idx]);
        mul_b = vm_q[cmd_i.idx];
      end
      afvr_pkg::MUL_VM_LIM: begin
        mul_a = 84'(vm_q[cmd_i.idx]);
        mul_b = 41'(limit_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    s_rem2  = {srem_q, rad_q[83:82]};
    s_trial = 46'({root_q, 2'b01});
    d_rem2  = {drem_q, num_q[71]};

    vmag   = reached_q ? 31'd0 : vm_q[cmd_i.idx][30:0];
    sprod  = 55'(step_q) * 55'(vmag);
    step_s = neg_q[cmd_i.idx] ? -$signed({3'b000, sprod[54:24]})
                              :  $signed({3'b000, sprod[54:24]});
    rsum   = $signed({{2{pos_q[cmd_i.idx][31]}}, pos_q[cmd_i.idx]}) + step_s;
    if (rsum > 34'sd2147483647) begin
      ref_w = 32'h7fff_ffff;
    end else if (rsum < -34'sd2147483648) begin
      ref_w = 32'h8000_0000;
    end else begin
      ref_w = rsum[31:0];
    end
    vel_w = neg_q[cmd_i.idx] ? 32'(-{1'b0, vmag}) : {1'b0, vmag};
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      afvr_pkg::DP_POSE: begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
      end
      afvr_pkg::DP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= e_w[i][33];
          em_q[i]  <= e_w[i][33] ? 33'(-e_w[i]) : e_w[i][32:0];
        end
        thr_sq_q <= 62'(thr_q) * 62'(thr_q);
        lim_sq_q <= 62'(limit_q) * 62'(limit_q);
      end
      afvr_pkg::DP_GAIN: vm_q[cmd_i.idx] <= gprod[48:8];
      afvr_pkg::DP_MUL_START: begin
        if (cmd_i.acc_clr) begin
          acc_q <= '0;
        end
        mcand_q  <= mul_a;
        mplier_q <= mul_b;
      end
      afvr_pkg::DP_MUL_STEP: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[82:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[40:1]};
      end
      afvr_pkg::DP_SAVE_E: reached_q <= {22'd0, thr_sq_q} > acc_q;
      afvr_pkg::DP_SQRT_INIT: begin
        rad_q  <= acc_q;
        srem_q <= '0;
        root_q <= '0;
      end
      afvr_pkg::DP_SQRT_STEP: begin
        rad_q <= {rad_q[81:0], 2'b00};
        if (s_rem2 >= s_trial) begin
          srem_q <= 44'(s_rem2 - s_trial);
          root_q <= {root_q[40:0], 1'b1};
        end else begin
          srem_q <= s_rem2[43:0];
          root_q <= {root_q[40:0], 1'b0};
        end
      end
      afvr_pkg::DP_DIV_INIT: begin
        num_q  <= acc_q[71:0];
        drem_q <= '0;
        quo_q  <= '0;
      end
      afvr_pkg::DP_DIV_STEP: begin
        num_q <= {num_q[70:0], 1'b0};
        if (d_rem2 >= {1'b0, root_q}) begin
          drem_q <= 42'(d_rem2 - {1'b0, root_q});
          quo_q  <= {quo_q[29:0], 1'b1};
        end else begin
          drem_q <= d_rem2[41:0];
          quo_q  <= {quo_q[29:0], 1'b0};
        end
      end
      afvr_pkg::DP_DIV_SAVE: vm_q[cmd_i.idx] <= 41'(quo_q);
      afvr_pkg::DP_OUT: begin
        ref_q[cmd_i.idx] <= ref_w;
        vel_q[cmd_i.idx] <= vel_w;
      end
      default: ;
    endcase
  end

  assign status_o.clip    = acc_q > {22'd0, lim_sq_q};
  assign status_o.reached = reached_q;

  assign ref_x_o     = ref_q[0];
  assign ref_y_o     = ref_q[1];
  assign ref_z_o     = ref_q[2];
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];
  assign at_target_o = reached_q;

endmodule

@@ rtl/core/afvr_ctrl.sv @@
// ============================================================================
// afvr_ctrl - sequencer
// Accepts items, tracks whether a pose is held and steps the datapath
// through error, velocity, clipping and output phases.
// ============================================================================
module afvr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  afvr_pkg::dp_status_t status_i,
  output afvr_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_LOAD   = 18'h00002,
    ST_GAIN   = 18'h00004,
    ST_ESTART = 18'h00008,
    ST_ESTEP  = 18'h00010,
    ST_ESAVE  = 18'h00020,
    ST_VSTART = 18'h00040,
    ST_VSTEP  = 18'h00080,
    ST_VSAVE  = 18'h00100,
    ST_SQINIT = 18'h00200,
    ST_SQSTEP = 18'h00400,
    ST_NSTART = 18'h00800,
    ST_NSTEP  = 18'h01000,
    ST_DINIT  = 18'h02000,
    ST_DSTEP  = 18'h04000,
    ST_DSAVE  = 18'h08000,
    ST_OUT    = 18'h10000,
    ST_HOLD   = 18'h20000
  } state_e;

  localparam logic [afvr_pkg::CNT_W-1:0] MulLast  = afvr_pkg::CNT_W'(afvr_pkg::MUL_STEPS - 1);
  localparam logic [afvr_pkg::CNT_W-1:0] SqrtLast = afvr_pkg::CNT_W'(afvr_pkg::SQRT_STEPS - 1);
  localparam logic [afvr_pkg::CNT_W-1:0] DivLast  = afvr_pkg::CNT_W'(afvr_pkg::DIV_STEPS - 1);

  state_e                     state_q, state_d;
  logic [afvr_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]                 idx_q, idx_d;
  logic                       have_pose_q, have_pose_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    have_pose_d   = have_pose_q;
    cmd_o.op      = afvr_pkg::DP_NOP;
    cmd_o.idx     = idx_q;
    cmd_o.src     = afvr_pkg::MUL_EM_SQ;
    cmd_o.acc_clr = 1'b0;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        if (in_valid_i) begin
          if (in_op_i == afvr_pkg::OP_POSE) begin
            cmd_o.op    = afvr_pkg::DP_POSE;
            have_pose_d = 1'b1;
          end else if (have_pose_q) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.op = afvr_pkg::DP_LOAD;
        state_d  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.op = afvr_pkg::DP_GAIN;
        idx_d    = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_ESTART;
        end
      end
      ST_ESTART: begin
        cmd_o.op      = afvr_pkg::DP_MUL_START;
        cmd_o.acc_clr = (idx_q == 2'd0);
        cnt_d         = '0;
        state_d       = ST_ESTEP;
      end
      ST_ESTEP: begin
        cmd_o.op = afvr_pkg::DP_MUL_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          idx_d   = idx_q + 2'd1;
          state_d = (idx_q == 2'd2) ? ST_ESAVE : ST_ESTART;
        end
      end
      ST_ESAVE: begin
        cmd_o.op = afvr_pkg::DP_SAVE_E;
        idx_d    = '0;
        state_d  = ST_VSTART;
      end
      ST_VSTART: begin
        cmd_o.op      = afvr_pkg::DP_MUL_START;
        cmd_o.src     = afvr_pkg::MUL_VM_SQ;
        cmd_o.acc_clr = (idx_q == 2'd0);
        cnt_d         = '0;
        state_d       = ST_VSTEP;
      end
      ST_VSTEP: begin
        cmd_o.op  = afvr_pkg::DP_MUL_STEP;
        cmd_o.src = afvr_pkg::MUL_VM_SQ;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          idx_d   = idx_q + 2'd1;
          state_d = (idx_q == 2'd2) ? ST_VSAVE : ST_VSTART;
        end
      end
      ST_VSAVE: begin
        idx_d = '0;
        // a reached target zeroes the velocity, so skip the clipping pass
        state_d = (status_i.clip && !status_i.reached) ? ST_SQINIT : ST_OUT;
      end
      ST_SQINIT: begin
        cmd_o.op = afvr_pkg::DP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQSTEP;
      end
      ST_SQSTEP: begin
        cmd_o.op = afvr_pkg::DP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == SqrtLast) begin
          state_d = ST_NSTART;
        end
      end
      ST_NSTART: begin
        cmd_o.op      = afvr_pkg::DP_MUL_START;
        cmd_o.src     = afvr_pkg::MUL_VM_LIM;
        cmd_o.acc_clr = 1'b1;
        cnt_d         = '0;
        state_d       = ST_NSTEP;
      end
      ST_NSTEP: begin
        cmd_o.op  = afvr_pkg::DP_MUL_STEP;
        cmd_o.src = afvr_pkg::MUL_VM_LIM;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          state_d = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd_o.op = afvr_pkg::DP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd_o.op = afvr_pkg::DP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_DSAVE;
        end
      end
      ST_DSAVE: begin
        cmd_o.op = afvr_pkg::DP_DIV_SAVE;
        idx_d    = idx_q + 2'd1;
        state_d  = ST_NSTART;
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd_o.op = afvr_pkg::DP_OUT;
        idx_d    = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      have_pose_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      have_pose_q <= have_pose_d;
    end
  end

endmodule

@@ rtl/core/attractive_field_velocity_reference.sv @@
// ============================================================================
// attractive_field_velocity_reference - potential-field velocity reference
// Turns the held 3D pose into a clipped velocity and a next reference point.
// ============================================================================
// Usage:
//   Slave stream: tuser carries the item kind (pose or tick), tdata the
//   position. A pose beat is stored when it is accepted and gives no result. A tick
//   beat before any pose is dropped. Otherwise a tick yields one master beat
//   with reference position, velocity and the reached flag.
//   One item is worked at a time; tready is high only when the block is idle.
//   A stalled result beat holds until taken; no new beat is accepted meanwhile.
//   Reset restores the register defaults and forgets the pose.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i by the user
//   only while idle; the block itself does not enforce this.
// ============================================================================
module attractive_field_velocity_reference (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic         s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // ref_x, ref_y, ref_z, vel_x, vel_y, vel_z,
                                       // at_target, zero fill
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  afvr_pkg::dp_cmd_t    cmd;
  afvr_pkg::dp_status_t status;
  logic [31:0] ref_x, ref_y, ref_z, vel_x, vel_y, vel_z;
  logic        at_target;

  afvr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  afvr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pos_x_i     (s_axis_tdata[31:0]),
    .pos_y_i     (s_axis_tdata[63:32]),
    .pos_z_i     (s_axis_tdata[95:64]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .ref_x_o     (ref_x),
    .ref_y_o     (ref_y),
    .ref_z_o     (ref_z),
    .vel_x_o     (vel_x),
    .vel_y_o     (vel_y),
    .vel_z_o     (vel_z),
    .at_target_o (at_target)
  );

  assign m_axis_tdata = {7'd0, at_target, vel_z, vel_y, vel_x, ref_z, ref_y, ref_x};

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("result pending while input is open");

  a_tick_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == afvr_pkg::OP_TICK))
    else $error("work started without a tick beat");

  a_reached_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[192]) |-> (m_axis_tdata[191:96] == '0))
    else $error("velocity not zero at target");

endmodule

@@ sim/tb_attractive_field_velocity_reference.sv @@
// ============================================================================
// tb_attractive_field_velocity_reference - stream testbench
// Drives pose and tick beats with random gaps, predicts the reference
// position, velocity and reached flag per tick, and checks every result beat.
// ============================================================================
module tb_attractive_field_velocity_reference;

  localparam int TICK_LAT  = 700;
  localparam int MAX_CYC   = 4000000;
  localparam int N_RANDOM  = 1900;

  typedef struct packed {
    logic        at_target;
    logic [31:0] vel_z;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] ref_z;
    logic [31:0] ref_y;
    logic [31:0] ref_x;
  } guide_t;

  typedef struct {
    logic        op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        known;   // expected value typed in
    guide_t      want;
  } stim_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  attractive_field_velocity_reference i_dut (.*);

  always #6 clk_i = ~clk_i;

  // model state
  logic signed [31:0] tgt_q [3];
  logic [15:0]        gain_q;
  logic [30:0]        limit_q;
  logic [30:0]        thresh_q;
  logic [23:0]        dt_q;
  logic signed [31:0] pose_q [3];
  logic               have_pose_q;

  guide_t guide_q[$];
  int     errors = 0;
  int     cycles = 0;
  bit     hold_long = 0;

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 45; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic guide_t predict_guide();
    guide_t g;
    logic signed [33:0]  e [3];
    logic [127:0]        em [3];
    logic [127:0]        vm [3];
    logic [127:0]        vsq, esq, nrm, sm;
    logic signed [63:0]  r;
    bit                  neg [3];
    bit                  hit;
    for (int i = 0; i < 3; i++) begin
      e[i]   = 34'(tgt_q[i]) - 34'(pose_q[i]);
      neg[i] = e[i] < 0;
      em[i]  = neg[i] ? 128'(-e[i]) : 128'(e[i]);
      vm[i]  = (em[i] * gain_q) >> 8;
    end
    vsq = vm[0]*vm[0] + vm[1]*vm[1] + vm[2]*vm[2];
    if (vsq > 128'(limit_q) * limit_q) begin
      nrm = isqrt(vsq);
      for (int i = 0; i < 3; i++) vm[i] = vm[i] * limit_q / nrm;
    end
    esq = em[0]*em[0] + em[1]*em[1] + em[2]*em[2];
    hit = 128'(thresh_q) * thresh_q > esq;
    for (int i = 0; i < 3; i++) begin
      if (hit) vm[i] = '0;
      sm = (vm[i] * dt_q) >> 24;
      r  = 64'(pose_q[i]) + (neg[i] ? -64'(sm) : 64'(sm));
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      case (i)
        0: begin g.ref_x = r[31:0]; g.vel_x = neg[i] ? -vm[i][31:0] : vm[i][31:0]; end
        1: begin g.ref_y = r[31:0]; g.vel_y = neg[i] ? -vm[i][31:0] : vm[i][31:0]; end
        default: begin
          g.ref_z = r[31:0]; g.vel_z = neg[i] ? -vm[i][31:0] : vm[i][31:0];
        end
      endcase
    end
    g.at_target = hit;
    return g;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      afvr_pkg::REG_TARGET_X:  tgt_q[0] = val;
      afvr_pkg::REG_TARGET_Y:  tgt_q[1] = val;
      afvr_pkg::REG_TARGET_Z:  tgt_q[2] = val;
      afvr_pkg::REG_GAIN:      gain_q   = val[15:0];
      afvr_pkg::REG_LIMIT:     limit_q  = val[30:0];
      afvr_pkg::REG_THRESHOLD: thresh_q = val[30:0];
      afvr_pkg::REG_STEP_TIME: dt_q     = val[23:0];
      default: ;
    endcase
  endtask

  // send one beat; predict and queue at acceptance
  task automatic send_beat(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           bit known, guide_t want);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == afvr_pkg::OP_POSE) begin
      pose_q[0] = px; pose_q[1] = py; pose_q[2] = pz;
      have_pose_q = 1'b1;
    end else if (have_pose_q) begin
      guide_q.push_back(known ? want : predict_guide());
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (guide_q.size() != 0) @(negedge clk_i);
    repeat (TICK_LAT) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 67108864)) - 33554432);
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] t, int span);
    return t + 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // output checker
  always @(posedge clk_i) begin
    guide_t got, exp_g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[192:0];
      if (guide_q.size() == 0) begin
        $display("%0t: result beat with none expected: %h", $time, got);
        errors++;
      end else begin
        exp_g = guide_q.pop_front();
        if (got.ref_x !== exp_g.ref_x)
          $display("%0t: ref_x exp %h got %h", $time, exp_g.ref_x, got.ref_x);
        if (got.ref_y !== exp_g.ref_y)
          $display("%0t: ref_y exp %h got %h", $time, exp_g.ref_y, got.ref_y);
        if (got.ref_z !== exp_g.ref_z)
          $display("%0t: ref_z exp %h got %h", $time, exp_g.ref_z, got.ref_z);
        if (got.vel_x !== exp_g.vel_x)
          $display("%0t: vel_x exp %h got %h", $time, exp_g.vel_x, got.vel_x);
        if (got.vel_y !== exp_g.vel_y)
          $display("%0t: vel_y exp %h got %h", $time, exp_g.vel_y, got.vel_y);
        if (got.vel_z !== exp_g.vel_z)
          $display("%0t: vel_z exp %h got %h", $time, exp_g.vel_z, got.vel_z);
        if (got.at_target !== exp_g.at_target)
          $display("%0t: at_target exp %b got %b", $time, exp_g.at_target, got.at_target);
        if (got !== exp_g) errors++;
      end
    end
  end

  // receiver: random stall per beat, one long hold-off while the sender pushes
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_long = 0;
      end else begin
        stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("** attractive_field_velocity_reference: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_t  plan[$];
    stim_t  s;
    guide_t g;
    logic   op;
    tgt_q[0] = 32'd8388608; tgt_q[1] = 32'd3355443; tgt_q[2] = 32'd8388608;
    gain_q = 16'd1280; limit_q = 31'd16777216; thresh_q = 31'd1678; dt_q = 24'd33554;
    pose_q[0] = '0; pose_q[1] = '0; pose_q[2] = '0;
    have_pose_q = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: tick before pose is dropped; pose at target is reached
    g = '0; g.ref_x = 32'd8388608; g.ref_y = 32'd3355443; g.ref_z = 32'd8388608;
    g.at_target = 1'b1;
    plan.push_back('{afvr_pkg::OP_TICK, '0, '0, '0, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_POSE, 32'd8388608, 32'd3355443, 32'd8388608, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_TICK, '1, '1, '1, 1'b1, g});
    plan.push_back('{afvr_pkg::OP_POSE, '0, '0, '0, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_TICK, '0, '0, '0, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_POSE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     1'b0, '0});
    plan.push_back('{afvr_pkg::OP_TICK, '0, '0, '0, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_POSE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     1'b0, '0});
    plan.push_back('{afvr_pkg::OP_TICK, '0, '0, '0, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_POSE, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                     1'b0, '0});
    plan.push_back('{afvr_pkg::OP_TICK, '0, '0, '0, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_POSE, 32'd8388700, 32'd3355400, 32'd8388608, 1'b0, '0});
    plan.push_back('{afvr_pkg::OP_TICK, '0, '0, '0, 1'b0, '0});
    foreach (plan[i]) begin
      s = plan[i];
      send_beat(s.op, s.px, s.py, s.pz, s.known, s.want);
    end
    drain();

    // extremes of the registers, then zero threshold, zero gain and zero limit
    write_reg(afvr_pkg::REG_TARGET_X, 32'h7fff_ffff);
    write_reg(afvr_pkg::REG_TARGET_Y, 32'h8000_0000);
    write_reg(afvr_pkg::REG_TARGET_Z, 32'h0000_0000);
    write_reg(afvr_pkg::REG_GAIN, 32'hffff);
    write_reg(afvr_pkg::REG_LIMIT, 32'h7fff_ffff);
    write_reg(afvr_pkg::REG_THRESHOLD, 32'h7fff_ffff);
    write_reg(afvr_pkg::REG_STEP_TIME, 32'hff_ffff);
    send_beat(afvr_pkg::OP_POSE, 32'h8000_0000, 32'h7fff_ffff, '0, 0, '0);
    send_beat(afvr_pkg::OP_TICK, '0, '0, '0, 0, '0);
    drain();
    write_reg(afvr_pkg::REG_THRESHOLD, 32'd0);
    send_beat(afvr_pkg::OP_TICK, '0, '0, '0, 0, '0);
    drain();
    write_reg(afvr_pkg::REG_GAIN, 32'd0);
    send_beat(afvr_pkg::OP_TICK, '0, '0, '0, 0, '0);
    drain();
    write_reg(afvr_pkg::REG_LIMIT, 32'd0);
    write_reg(afvr_pkg::REG_GAIN, 32'd1);
    write_reg(afvr_pkg::REG_STEP_TIME, 32'd1);
    send_beat(afvr_pkg::OP_TICK, '0, '0, '0, 0, '0);
    drain();

    // random phases with varied settings; the first one uses the long hold-off
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(afvr_pkg::REG_TARGET_X, rand_pos());
      write_reg(afvr_pkg::REG_TARGET_Y, rand_pos());
      write_reg(afvr_pkg::REG_TARGET_Z, rand_pos());
      write_reg(afvr_pkg::REG_GAIN, (ph == 4) ? 32'hffff : $urandom_range(0, 4096));
      write_reg(afvr_pkg::REG_LIMIT,
                (ph == 3) ? 32'h7fff_ffff : $urandom_range(0, 32'h0800_0000));
      write_reg(afvr_pkg::REG_THRESHOLD,
                (ph == 2) ? 32'd0 : $urandom_range(0, 32'h0100_0000));
      write_reg(afvr_pkg::REG_STEP_TIME,
                (ph == 1) ? 32'hff_ffff : $urandom_range(1, 32'hff_ffff));
      if (ph == 0) hold_long = 1;
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        op = ($urandom_range(0, 2) != 0) ? afvr_pkg::OP_TICK : afvr_pkg::OP_POSE;
        if ($urandom_range(0, 3) == 0)
          send_beat(op, near(tgt_q[0], 3000), near(tgt_q[1], 3000),
                    near(tgt_q[2], 3000), 0, '0);
        else
          send_beat(op, rand_pos(), rand_pos(), rand_pos(), 0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("** attractive_field_velocity_reference: PASSED **");
    end else begin
      $display("** attractive_field_velocity_reference: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/afvr_pkg.sv
rtl/core/afvr_dp.sv
rtl/core/afvr_ctrl.sv
rtl/core/attractive_field_velocity_reference.sv
sim/tb_attractive_field_velocity_reference.sv
